// ===== rtl/box_average_downscale_unit_defines.svh =====
// Assertion macros for the box average downscale unit.
// Used by the port checker; no other dependencies.
`ifndef BOX_AVERAGE_DOWNSCALE_UNIT_DEFINES_SVH
`define BOX_AVERAGE_DOWNSCALE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BADU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BADU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/boxavg_pkg.sv =====
// Shared types, constants and reciprocal tables for the box average downscaler.
// No dependencies.
package boxavg_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_FACTOR = 8;

  localparam int PIX_W  = 8;
  localparam int SUM_W  = 14;
  localparam int COL_W  = 10;
  localparam int DIM_W  = 11;
  localparam int FAC_W  = 4;
  localparam int PH_W   = 3;
  localparam int IDX_W  = 2;
  localparam int ADDR_W = $clog2(MAX_WIDTH);

  // Reciprocal of the block area, scaled by 2**AREA_SHIFT and rounded up.
  localparam int AREA_SHIFT   = 20;
  localparam int AREA_RECIP_W = 21;
  localparam int AREA_PROD_W  = SUM_W + AREA_RECIP_W;

  // Reciprocal of the factor, scaled by 2**DIM_SHIFT and rounded up.
  localparam int DIM_SHIFT   = 14;
  localparam int DIM_RECIP_W = 15;
  localparam int DIM_PROD_W  = DIM_W + DIM_RECIP_W;

  // Cycles for a register write to reach the derived limits.
  localparam int SETTLE_W = 2;
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

  typedef enum logic [IDX_W-1:0] {
    REG_SHRINK_FACTOR = 2'd0,
    REG_IMAGE_WIDTH   = 2'd1,
    REG_IMAGE_HEIGHT  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic accept;   // input beat taken this cycle
    logic sum_en;   // update line store entry
    logic mul_en;   // scale sums by the area reciprocal
    logic push;     // load the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic busy;     // derived limits still settling
    logic emit;     // latched beat completes a block
    logic out_free; // output register can take a result
  } dp_status_t;

  function automatic logic [AREA_RECIP_W-1:0] area_recip(input logic [FAC_W-1:0] f);
    logic [AREA_RECIP_W-1:0] m;
    case (f)
      4'd1:    m = 21'd1048576;
      4'd2:    m = 21'd262144;
      4'd3:    m = 21'd116509;
      4'd4:    m = 21'd65536;
      4'd5:    m = 21'd41944;
      4'd6:    m = 21'd29128;
      4'd7:    m = 21'd21400;
      4'd8:    m = 21'd16384;
      default: m = 21'd1048576;
    endcase
    return m;
  endfunction

  function automatic logic [DIM_RECIP_W-1:0] dim_recip(input logic [FAC_W-1:0] f);
    logic [DIM_RECIP_W-1:0] m;
    case (f)
      4'd1:    m = 15'd16384;
      4'd2:    m = 15'd8192;
      4'd3:    m = 15'd5462;
      4'd4:    m = 15'd4096;
      4'd5:    m = 15'd3277;
      4'd6:    m = 15'd2731;
      4'd7:    m = 15'd2341;
      4'd8:    m = 15'd2048;
      default: m = 15'd16384;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/boxavg_ctrl.sv =====
// Controller state machine of the box average downscaler.
// Depends on boxavg_pkg; drives boxavg_datapath through command and status structs.
module boxavg_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  boxavg_pkg::dp_status_t status,
  output boxavg_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_PUSH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = !rst && (state == ST_IDLE) && !status.busy;

  always_comb begin
    cmd.accept = in_valid && in_ready;
    cmd.sum_en = (state == ST_SUM);
    cmd.mul_en = (state == ST_MUL);
    cmd.push   = (state == ST_PUSH) && status.out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.accept) state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = status.emit ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/boxavg_datapath.sv =====
// Datapath of the box average downscaler: registers, position counters,
// column-sum line store, reciprocal scaling and output register. Uses boxavg_pkg.
module boxavg_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [boxavg_pkg::IDX_W-1:0]        cfg_index,
  input  logic [boxavg_pkg::DIM_W-1:0]        cfg_data,
  input  logic [boxavg_pkg::PIX_W-1:0]        red_in,
  input  logic [boxavg_pkg::PIX_W-1:0]        green_in,
  input  logic [boxavg_pkg::PIX_W-1:0]        blue_in,
  input  boxavg_pkg::ctrl_cmd_t               cmd,
  output boxavg_pkg::dp_status_t              status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [boxavg_pkg::PIX_W-1:0]        red_out,
  output logic [boxavg_pkg::PIX_W-1:0]        green_out,
  output logic [boxavg_pkg::PIX_W-1:0]        blue_out,
  output logic                                frame_last
);

  localparam int SW = boxavg_pkg::SUM_W;
  localparam int PW = boxavg_pkg::PIX_W;
  localparam int DW = boxavg_pkg::DIM_W;
  localparam int CW = boxavg_pkg::COL_W;
  localparam int FW = boxavg_pkg::FAC_W;
  localparam int HW = boxavg_pkg::PH_W;
  localparam int AS = boxavg_pkg::AREA_SHIFT;
  localparam int DS = boxavg_pkg::DIM_SHIFT;
  localparam int DPW = boxavg_pkg::DIM_PROD_W;
  localparam int APW = boxavg_pkg::AREA_PROD_W;
  localparam int LPW = DW + FW;

  // Configuration registers.
  logic [FW-1:0] shrink_factor;
  logic [DW-1:0] image_width;
  logic [DW-1:0] image_height;
  logic [boxavg_pkg::SETTLE_W-1:0] settle;

  // Derived limits, three register stages behind the configuration.
  logic [FW-1:0] fac;
  logic [DW-1:0] wid;
  logic [DW-1:0] hgt;
  logic [DW-1:0] out_w;
  logic [DW-1:0] out_h;
  logic [DW-1:0] lim_w;
  logic [DW-1:0] lim_h;
  logic [boxavg_pkg::AREA_RECIP_W-1:0] area_m;
  logic [boxavg_pkg::DIM_PROD_W-1:0]   w_prod;
  logic [boxavg_pkg::DIM_PROD_W-1:0]   h_prod;
  logic [DW+FW-1:0] lw_prod;
  logic [DW+FW-1:0] lh_prod;

  // Position counters.
  logic [CW-1:0] input_column;
  logic [CW-1:0] input_row;
  logic [HW-1:0] column_phase;
  logic [HW-1:0] row_phase;
  logic [CW-1:0] output_column;
  logic [CW-1:0] input_column_next;
  logic [CW-1:0] input_row_next;
  logic [HW-1:0] column_phase_next;
  logic [HW-1:0] row_phase_next;
  logic [CW-1:0] output_column_next;

  logic col_end;
  logic row_end;
  logic line_end;
  logic frame_end;
  logic in_block;
  logic emit;
  logic last;

  // Beat latched at accept.
  logic [PW-1:0] red_q;
  logic [PW-1:0] green_q;
  logic [PW-1:0] blue_q;
  logic          first_q;
  logic          in_block_q;
  logic          emit_q;
  logic          last_q;
  logic [boxavg_pkg::ADDR_W-1:0] addr_q;

  // Line store: red, green and blue column sums side by side.
  logic [3*SW-1:0] sums_mem [boxavg_pkg::MAX_WIDTH];
  logic [3*SW-1:0] rd_data;
  logic [SW-1:0]   red_new;
  logic [SW-1:0]   green_new;
  logic [SW-1:0]   blue_new;
  logic [SW-1:0]   red_sum;
  logic [SW-1:0]   green_sum;
  logic [SW-1:0]   blue_sum;
  logic [boxavg_pkg::AREA_PROD_W-1:0] red_prod;
  logic [boxavg_pkg::AREA_PROD_W-1:0] green_prod;
  logic [boxavg_pkg::AREA_PROD_W-1:0] blue_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      shrink_factor <= 4'd1;
      image_width   <= 11'd1024;
      image_height  <= 11'd1024;
      settle        <= boxavg_pkg::SETTLE_CYCLES;
    end else begin
      if (cfg_we) begin
        settle <= boxavg_pkg::SETTLE_CYCLES;
        case (cfg_index)
          boxavg_pkg::REG_SHRINK_FACTOR: shrink_factor <= cfg_data[FW-1:0];
          boxavg_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data;
          boxavg_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
          default: begin
          end
        endcase
      end else if (settle != '0) begin
        settle <= settle - 1'b1;
      end
    end
  end

  assign w_prod  = DPW'(wid) * DPW'(boxavg_pkg::dim_recip(fac));
  assign h_prod  = DPW'(hgt) * DPW'(boxavg_pkg::dim_recip(fac));
  assign lw_prod = LPW'(out_w) * LPW'(fac);
  assign lh_prod = LPW'(out_h) * LPW'(fac);

  always_ff @(posedge clk) begin
    // Stage one: saturate the registers into their legal ranges.
    if (shrink_factor == '0)
      fac <= 4'd1;
    else if (shrink_factor > 4'(boxavg_pkg::MAX_FACTOR))
      fac <= 4'(boxavg_pkg::MAX_FACTOR);
    else
      fac <= shrink_factor;
    if (image_width == '0)
      wid <= 11'd1;
    else if (image_width > 11'(boxavg_pkg::MAX_WIDTH))
      wid <= 11'(boxavg_pkg::MAX_WIDTH);
    else
      wid <= image_width;
    if (image_height == '0)
      hgt <= 11'd1;
    else if (image_height > 11'(boxavg_pkg::MAX_HEIGHT))
      hgt <= 11'(boxavg_pkg::MAX_HEIGHT);
    else
      hgt <= image_height;
    // Stage two: output size through the factor reciprocal.
    out_w  <= w_prod[DS+DW-1:DS];
    out_h  <= h_prod[DS+DW-1:DS];
    area_m <= boxavg_pkg::area_recip(fac);
    // Stage three: extent of the whole blocks in input pixels.
    lim_w <= lw_prod[DW-1:0];
    lim_h <= lh_prod[DW-1:0];
  end

  always_comb begin
    col_end   = ({1'b0, column_phase} + 4'd1) >= fac;
    row_end   = ({1'b0, row_phase} + 4'd1) >= fac;
    line_end  = ({1'b0, input_column} + 11'd1) >= wid;
    frame_end = ({1'b0, input_row} + 11'd1) >= hgt;
    in_block  = ({1'b0, input_column} < lim_w) && ({1'b0, input_row} < lim_h) &&
                ({1'b0, output_column} < out_w);
    emit      = in_block && col_end && row_end;
    last      = (({1'b0, output_column} + 11'd1) == out_w) &&
                (({1'b0, input_row} + 11'd1) == lim_h);

    if (col_end) begin
      column_phase_next  = '0;
      output_column_next = output_column + 1'b1;
    end else begin
      column_phase_next  = column_phase + 1'b1;
      output_column_next = output_column;
    end
    row_phase_next = row_phase;
    input_row_next = input_row;
    if (line_end) begin
      input_column_next  = '0;
      column_phase_next  = '0;
      output_column_next = '0;
      row_phase_next     = row_end ? '0 : row_phase + 1'b1;
      if (frame_end) begin
        input_row_next = '0;
        row_phase_next = '0;
      end else begin
        input_row_next = input_row + 1'b1;
      end
    end else begin
      input_column_next = input_column + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_column  <= '0;
      input_row     <= '0;
      column_phase  <= '0;
      row_phase     <= '0;
      output_column <= '0;
    end else if (cmd.accept) begin
      input_column  <= input_column_next;
      input_row     <= input_row_next;
      column_phase  <= column_phase_next;
      row_phase     <= row_phase_next;
      output_column <= output_column_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      red_q      <= red_in;
      green_q    <= green_in;
      blue_q     <= blue_in;
      first_q    <= (column_phase == '0) && (row_phase == '0);
      in_block_q <= in_block;
      emit_q     <= emit;
      last_q     <= last;
      addr_q     <= output_column;
    end
  end

  // The first pixel of a block restarts its column sum.
  always_comb begin
    if (first_q) begin
      red_new   = {{(SW-PW){1'b0}}, red_q};
      green_new = {{(SW-PW){1'b0}}, green_q};
      blue_new  = {{(SW-PW){1'b0}}, blue_q};
    end else begin
      red_new   = rd_data[3*SW-1:2*SW] + {{(SW-PW){1'b0}}, red_q};
      green_new = rd_data[2*SW-1:SW]   + {{(SW-PW){1'b0}}, green_q};
      blue_new  = rd_data[SW-1:0]      + {{(SW-PW){1'b0}}, blue_q};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_data <= sums_mem[output_column];
    end
    if (cmd.sum_en && in_block_q) begin
      sums_mem[addr_q] <= {red_new, green_new, blue_new};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      red_sum   <= red_new;
      green_sum <= green_new;
      blue_sum  <= blue_new;
    end
    if (cmd.mul_en) begin
      red_prod   <= APW'(red_sum) * APW'(area_m);
      green_prod <= APW'(green_sum) * APW'(area_m);
      blue_prod  <= APW'(blue_sum) * APW'(area_m);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      red_out    <= red_prod[AS+PW-1:AS];
      green_out  <= green_prod[AS+PW-1:AS];
      blue_out   <= blue_prod[AS+PW-1:AS];
      frame_last <= last_q;
    end
  end

  always_comb begin
    status.busy     = (settle != '0);
    status.emit     = emit_q;
    status.out_free = !out_valid || out_ready;
  end

endmodule

// ===== rtl/box_average_downscale_unit.sv =====
// Top level of the box average downscaler.
// Depends on boxavg_pkg, boxavg_ctrl and boxavg_datapath.
//
// Pixels enter in raster order on the input channel (in_valid/in_ready), one
// RGB beat per pixel. Each output beat (out_valid/out_ready) is the truncated
// per-channel mean of one factor-by-factor block, sent when the block's
// bottom-right pixel arrives; frame_last marks the frame's final block.
// Pixels right of the last whole block column or below the last whole band
// are consumed without output.
// A beat that completes no block goes through the line store read and update;
// one that completes a block also goes through the reciprocal multiply of the
// sums and the output register load, and only then is the next pixel taken.
// The output register holds a result while the receiver stalls; the next pixel
// is still taken, and the following result waits until the register drains.
// Registers are written through cfg_we/cfg_index/cfg_data; in_ready stays low
// after a write or reset while the block limits are recomputed.
// Reset restores factor 1 and a 1024 by 1024 frame and clears the position
// counters; the column sums are not cleared, each block starts its own sum.
module box_average_downscale_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [boxavg_pkg::IDX_W-1:0]     cfg_index,
  input  logic [boxavg_pkg::DIM_W-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [boxavg_pkg::PIX_W-1:0]     red_in,
  input  logic [boxavg_pkg::PIX_W-1:0]     green_in,
  input  logic [boxavg_pkg::PIX_W-1:0]     blue_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [boxavg_pkg::PIX_W-1:0]     red_out,
  output logic [boxavg_pkg::PIX_W-1:0]     green_out,
  output logic [boxavg_pkg::PIX_W-1:0]     blue_out,
  output logic                             frame_last
);

  boxavg_pkg::ctrl_cmd_t  cmd;
  boxavg_pkg::dp_status_t status;

  boxavg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  boxavg_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .red_in     (red_in),
    .green_in   (green_in),
    .blue_in    (blue_in),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .frame_last (frame_last)
  );

endmodule

// ===== rtl/box_average_downscale_unit_checker.sv =====
// Port-level checker for box_average_downscale_unit, bound to the top level.
// Depends on boxavg_pkg and box_average_downscale_unit_defines.svh.
`include "box_average_downscale_unit_defines.svh"

module box_average_downscale_unit_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             cfg_we,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [boxavg_pkg::PIX_W-1:0]     red_out,
  input logic [boxavg_pkg::PIX_W-1:0]     green_out,
  input logic [boxavg_pkg::PIX_W-1:0]     blue_out,
  input logic                             frame_last
);

  // A stalled output beat stays offered and unchanged.
  `BADU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output beat dropped while stalled")
  `BADU_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(frame_last), "output beat changed while stalled")

  // One pixel is worked on at a time.
  `BADU_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input taken while a pixel is in flight")

  // A register write holds off input while the limits settle.
  `BADU_ASSERT_NEXT(a_cfg_settle, cfg_we, !in_ready, "input taken right after a register write")

  // A fresh result shows after the sum, multiply and push states that follow the edge that took its pixel.
  `BADU_ASSERT_SAME(a_out_origin, $rose(out_valid), $past(in_valid && in_ready, 4), "result without a matching input beat")

endmodule

bind box_average_downscale_unit box_average_downscale_unit_checker u_checker (.*);
